// File: sv/minimum_window_cover_defines.svh
// Assertion macros used by the checker of the minimum window cover block.
// The checker supplies i_clk and i_rst_n in its own scope.
`ifndef MINIMUM_WINDOW_COVER_DEFINES_SVH
`define MINIMUM_WINDOW_COVER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MWC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MWC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/mwc_pkg.sv
// Shared types and constants of the minimum window cover block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package mwc_pkg;

    localparam int ALPHABET_SIZE_DEF = 26;
    localparam int MAX_TEXT_DEF      = 1024;
    localparam int QUEUE_DEPTH       = 2;

    localparam int OP_W     = 2;
    localparam int SYMBOL_W = 5;
    localparam int START_W  = 10;
    localparam int LENGTH_W = 11;

    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd0;
    localparam logic [OP_W-1:0] OP_PATTERN = 2'd1;
    localparam logic [OP_W-1:0] OP_TEXT    = 2'd2;

    typedef enum logic [1:0] {
        CMD_NOP,
        CMD_CLEAR,
        CMD_PAT,
        CMD_TEXT
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [SYMBOL_W-1:0]  symbol;
    } t_cmd;

    typedef struct packed {
        logic                 found;
        logic [START_W-1:0]   best_start;
        logic [LENGTH_W-1:0]  best_length;
        logic                 overflow;
    } t_result;

endpackage

`default_nettype wire

// File: sv/mwc_fifo.sv
// Small FIFO of flops: one beat in per cycle unless full, one out unless empty.
// Depends on mwc_pkg for its default depth; DEPTH must be a power of two.
`default_nettype none

module mwc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = mwc_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    import mwc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// File: sv/mwc_front.sv
// Front end: takes input beats, sorts them into commands and queues them.
// Depends on mwc_pkg and mwc_fifo.
`default_nettype none

module mwc_front #(
    parameter int ALPHABET_SIZE = mwc_pkg::ALPHABET_SIZE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic [mwc_pkg::OP_W-1:0]      i_op,
    input  logic [mwc_pkg::SYMBOL_W-1:0]  i_symbol,
    output logic                          o_full,
    input  logic                          i_pop,
    output logic                          o_empty,
    output mwc_pkg::t_cmd                 o_cmd
);
    import mwc_pkg::*;

    t_cmd cmd_in;
    logic sym_ok;

    assign sym_ok = (32'(i_symbol) < 32'(ALPHABET_SIZE));

    always_comb begin
        cmd_in.symbol = i_symbol;
        case (i_op)
            OP_CLEAR:   cmd_in.kind = CMD_CLEAR;
            OP_PATTERN: cmd_in.kind = sym_ok ? CMD_PAT : CMD_NOP;
            OP_TEXT:    cmd_in.kind = sym_ok ? CMD_TEXT : CMD_NOP;
            default:    cmd_in.kind = CMD_NOP;
        endcase
    end

    mwc_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (cmd_in),
        .o_full  (o_full),
        .i_pop   (i_pop),
        .o_empty (o_empty),
        .o_data  (o_cmd)
    );

endmodule

`default_nettype wire

// File: sv/mwc_back.sv
// Back end: carries out queued commands on the text store and need table.
// Depends on mwc_pkg; drives one result per command into the result queue.
`default_nettype none

module mwc_back #(
    parameter int ALPHABET_SIZE = mwc_pkg::ALPHABET_SIZE_DEF,
    parameter int MAX_TEXT      = mwc_pkg::MAX_TEXT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_empty,
    input  mwc_pkg::t_cmd     i_cmd,
    output logic              o_cmd_pop,
    input  logic              i_res_full,
    output logic              o_res_push,
    output mwc_pkg::t_result  o_result
);
    import mwc_pkg::*;

    localparam int POS_W  = $clog2(MAX_TEXT);
    localparam int LEN_W  = $clog2(MAX_TEXT + 1);
    localparam int NEED_W = LEN_W + 1;
    localparam int SYM_W  = $clog2(ALPHABET_SIZE);
    localparam logic signed [NEED_W-1:0] NEED_ONE = NEED_W'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAT_UPD,
        S_TXT_UPD,
        S_SHR_RD,
        S_SHR_SYM,
        S_SHR_CHK,
        S_BEST,
        S_EMIT
    } t_state;

    t_state             r_state, n_state;
    logic [SYM_W-1:0]   r_sym, n_sym;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [POS_W-1:0]   r_left, n_left;
    logic [LEN_W-1:0]   r_text_len, n_text_len;
    logic [LEN_W-1:0]   r_pat_len, n_pat_len;
    logic [LEN_W-1:0]   r_missing, n_missing;
    logic [POS_W-1:0]   r_best_start, n_best_start;
    logic [LEN_W-1:0]   r_best_len, n_best_len;
    logic               r_found, n_found;
    logic               r_overflow, n_overflow;

    logic signed [NEED_W-1:0] r_need_mem [ALPHABET_SIZE];
    logic [SYM_W-1:0]         r_text_mem [MAX_TEXT];
    logic signed [NEED_W-1:0] r_need_q;
    logic [SYM_W-1:0]         r_text_q;
    logic [ALPHABET_SIZE-1:0] r_need_vld;
    logic                     r_need_vq;

    logic signed [NEED_W-1:0] need_val;
    logic signed [NEED_W-1:0] need_wdata;
    logic [SYM_W-1:0]         need_raddr;
    logic [SYM_W-1:0]         need_waddr;
    logic                     need_we;
    logic                     text_we;
    logic [POS_W-1:0]         text_raddr;
    logic [SYM_W-1:0]         cmd_sym;
    logic                     clear;
    logic [LEN_W-1:0]         miss_next;
    logic [LEN_W-1:0]         win_len;

    assign cmd_sym  = SYM_W'(i_cmd.symbol);
    assign need_val = r_need_vq ? r_need_q : '0;
    assign win_len  = LEN_W'(r_pos) - LEN_W'(r_left) + 1'b1;

    assign o_result.found       = r_found;
    assign o_result.best_start  = r_found ? START_W'(r_best_start) : '0;
    assign o_result.best_length = r_found ? LENGTH_W'(r_best_len) : '0;
    assign o_result.overflow    = r_overflow;

    always_comb begin
        n_state      = r_state;
        n_sym        = r_sym;
        n_pos        = r_pos;
        n_left       = r_left;
        n_text_len   = r_text_len;
        n_pat_len    = r_pat_len;
        n_missing    = r_missing;
        n_best_start = r_best_start;
        n_best_len   = r_best_len;
        n_found      = r_found;
        n_overflow   = r_overflow;
        need_raddr   = cmd_sym;
        need_waddr   = r_sym;
        need_wdata   = need_val + NEED_ONE;
        need_we      = 1'b0;
        text_we      = 1'b0;
        text_raddr   = r_left;
        clear        = 1'b0;
        o_cmd_pop    = 1'b0;
        o_res_push   = 1'b0;
        miss_next    = r_missing - LEN_W'(need_val > 0);
        case (r_state)
            S_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    n_sym     = cmd_sym;
                    n_state   = S_EMIT;
                    case (i_cmd.kind)
                        CMD_CLEAR: begin
                            clear        = 1'b1;
                            n_left       = '0;
                            n_text_len   = '0;
                            n_pat_len    = '0;
                            n_missing    = '0;
                            n_best_start = '0;
                            n_best_len   = '0;
                            n_found      = 1'b0;
                            n_overflow   = 1'b0;
                        end
                        CMD_PAT: begin
                            if (r_text_len == '0) begin
                                if (r_pat_len >= LEN_W'(MAX_TEXT)) begin
                                    n_overflow = 1'b1;
                                end else begin
                                    n_state = S_PAT_UPD;
                                end
                            end
                        end
                        CMD_TEXT: begin
                            if (r_text_len >= LEN_W'(MAX_TEXT)) begin
                                n_overflow = 1'b1;
                            end else begin
                                text_we    = 1'b1;
                                n_pos      = POS_W'(r_text_len);
                                n_text_len = r_text_len + 1'b1;
                                if (r_pat_len != '0) begin
                                    n_state = S_TXT_UPD;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_PAT_UPD: begin
                need_we    = 1'b1;
                need_wdata = need_val + NEED_ONE;
                n_pat_len  = r_pat_len + 1'b1;
                n_missing  = r_missing + 1'b1;
                n_state    = S_EMIT;
            end
            S_TXT_UPD: begin
                need_we    = 1'b1;
                need_wdata = need_val - NEED_ONE;
                n_missing  = miss_next;
                n_state    = (miss_next == '0) ? S_SHR_RD : S_EMIT;
            end
            S_SHR_RD: begin
                n_state = (r_left < r_pos) ? S_SHR_SYM : S_BEST;
            end
            S_SHR_SYM: begin
                need_raddr = r_text_q;
                n_sym      = r_text_q;
                n_state    = S_SHR_CHK;
            end
            S_SHR_CHK: begin
                if (need_val < 0) begin
                    need_we    = 1'b1;
                    need_wdata = need_val + NEED_ONE;
                    n_left     = r_left + 1'b1;
                    n_state    = S_SHR_RD;
                end else begin
                    n_state = S_BEST;
                end
            end
            S_BEST: begin
                if (!r_found || (win_len < r_best_len)) begin
                    n_found      = 1'b1;
                    n_best_start = r_left;
                    n_best_len   = win_len;
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_sym        <= '0;
            r_pos        <= '0;
            r_left       <= '0;
            r_text_len   <= '0;
            r_pat_len    <= '0;
            r_missing    <= '0;
            r_best_start <= '0;
            r_best_len   <= '0;
            r_found      <= 1'b0;
            r_overflow   <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_sym        <= n_sym;
            r_pos        <= n_pos;
            r_left       <= n_left;
            r_text_len   <= n_text_len;
            r_pat_len    <= n_pat_len;
            r_missing    <= n_missing;
            r_best_start <= n_best_start;
            r_best_len   <= n_best_len;
            r_found      <= n_found;
            r_overflow   <= n_overflow;
        end
    end

    // A need table entry that was not written since the last clear reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_need_vld <= '0;
            r_need_vq  <= 1'b0;
        end else begin
            if (clear) begin
                r_need_vld <= '0;
            end else if (need_we) begin
                r_need_vld[need_waddr] <= 1'b1;
            end
            r_need_vq <= r_need_vld[need_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (need_we) begin
            r_need_mem[need_waddr] <= need_wdata;
        end
        if (text_we) begin
            r_text_mem[POS_W'(r_text_len)] <= cmd_sym;
        end
        r_need_q <= r_need_mem[need_raddr];
        r_text_q <= r_text_mem[text_raddr];
    end

endmodule

`default_nettype wire

// File: sv/minimum_window_cover.sv
// Streaming minimum window search: op 0 clears the job, op 1 adds a pattern letter and
// op 2 adds a text letter; after every input beat one result beat gives the earliest of
// the shortest text windows seen so far that hold the whole pattern, plus an overflow flag.
// Input beats are queued, so the block takes new beats while it works, until the queue
// is full. A clear, an ignored beat or a text letter with an empty pattern goes straight
// to the result step; an accepted pattern letter, or a text letter with a pattern, first
// updates the need table. A text letter that covers the pattern then drops letters from
// the left edge while their need count is negative and the edge has not reached the new
// letter; each drop needs one read of the text store and then one read and one write of
// the need table. The best window is then updated. Each letter leaves the window once,
// and a full result queue holds the result step.
`default_nettype none

module minimum_window_cover #(
    parameter int ALPHABET_SIZE = mwc_pkg::ALPHABET_SIZE_DEF,
    parameter int MAX_TEXT      = mwc_pkg::MAX_TEXT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [mwc_pkg::OP_W-1:0]      i_op,
    input  logic [mwc_pkg::SYMBOL_W-1:0]  i_symbol,
    input  logic                          pop,
    output logic                          empty,
    output logic                          o_found,
    output logic [mwc_pkg::START_W-1:0]   o_best_start,
    output logic [mwc_pkg::LENGTH_W-1:0]  o_best_length,
    output logic                          o_overflow
);
    import mwc_pkg::*;

    t_cmd    cmd;
    logic    cmd_empty;
    logic    cmd_pop;
    t_result res_in;
    t_result res_out;
    logic    res_push;
    logic    res_full;

    mwc_front #(
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_op     (i_op),
        .i_symbol (i_symbol),
        .o_full   (full),
        .i_pop    (cmd_pop),
        .o_empty  (cmd_empty),
        .o_cmd    (cmd)
    );

    mwc_back #(
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .MAX_TEXT      (MAX_TEXT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_result    (res_in)
    );

    mwc_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (res_out)
    );

    assign o_found       = res_out.found;
    assign o_best_start  = res_out.best_start;
    assign o_best_length = res_out.best_length;
    assign o_overflow    = res_out.overflow;

endmodule

`default_nettype wire

// File: sv/mwc_checker.sv
// Port-level checks of the minimum window cover block, bound to its top level.
// Depends on mwc_pkg and on the macros in minimum_window_cover_defines.svh.
`default_nettype none

`include "minimum_window_cover_defines.svh"

module mwc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          push,
    input logic                          full,
    input logic [mwc_pkg::OP_W-1:0]      i_op,
    input logic [mwc_pkg::SYMBOL_W-1:0]  i_symbol,
    input logic                          pop,
    input logic                          empty,
    input logic                          o_found,
    input logic [mwc_pkg::START_W-1:0]   o_best_start,
    input logic [mwc_pkg::LENGTH_W-1:0]  o_best_length,
    input logic                          o_overflow
);
    import mwc_pkg::*;

    logic [3:0] r_outstanding;
    logic       in_beat;
    logic       out_beat;
    logic       sym_seen;

    assign in_beat  = push && !full;
    assign out_beat = pop && !empty;
    assign sym_seen = ^{i_op, i_symbol} || 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= '0;
        end else begin
            r_outstanding <= r_outstanding + 4'(in_beat) - 4'(out_beat);
        end
    end

    `MWC_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(o_found) && $stable(o_best_start) && $stable(o_best_length) && $stable(o_overflow), "waiting result beat changed")
    `MWC_ASSERT_SAME(a_no_extra_result, out_beat && sym_seen, r_outstanding != '0, "result beat without an input beat")
    `MWC_ASSERT_SAME(a_found_length, !empty && o_found, o_best_length != '0, "found window has zero length")
    `MWC_ASSERT_SAME(a_none_zero, !empty && !o_found, o_best_start == '0 && o_best_length == '0, "window fields set with nothing found")

endmodule

bind minimum_window_cover mwc_checker u_mwc_checker (.*);

`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench of the minimum window cover block: a stimulus table, random jobs
// and one long job that fills the text store, checked beat by beat against a predictor or
// the table's own results. Depends on mwc_pkg and the minimum_window_cover top level.
`default_nettype none

module testbench;
    import mwc_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int LETTERS      = ALPHABET_SIZE_DEF;
    localparam int TEXT_CAP     = MAX_TEXT_DEF;
    localparam int RANDOM_ITEMS = 200;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int ROW_COUNT    = 21;

    typedef struct {
        logic [OP_W-1:0]     op;
        logic [SYMBOL_W-1:0] sym;
        bit                  typed;
        t_result             res;
    } t_row;

    logic                i_clk    = 1'b0;
    logic                i_rst_n  = 1'b0;
    logic                push     = 1'b0;
    logic                pop      = 1'b0;
    logic [OP_W-1:0]     i_op     = '0;
    logic [SYMBOL_W-1:0] i_symbol = '0;
    logic                full;
    logic                empty;
    logic                o_found;
    logic [START_W-1:0]  o_best_start;
    logic [LENGTH_W-1:0] o_best_length;
    logic                o_overflow;

    int                  need_tab [LETTERS];
    logic [SYMBOL_W-1:0] text_mem [TEXT_CAP];
    int unsigned         pat_len, txt_len, miss_cnt, left_pos, win_start, win_len;
    bit                  win_found, ovf_seen;

    t_result     window_q [$];
    t_result     head_res;
    t_row        dir_rows [ROW_COUNT];
    int unsigned mismatch_count = 0;
    int unsigned stim_items = 0;
    int unsigned cycle_count = 0;
    int unsigned hold_left = 0;
    bit          hold_req = 1'b0;
    bit          hold_done = 1'b0;
    bit          no_idle = 1'b0;

    minimum_window_cover i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_op          (i_op),
        .i_symbol      (i_symbol),
        .pop           (pop),
        .empty         (empty),
        .o_found       (o_found),
        .o_best_start  (o_best_start),
        .o_best_length (o_best_length),
        .o_overflow    (o_overflow)
    );

    always #4 i_clk = ~i_clk;

    function automatic void clear_job();
        foreach (need_tab[k]) need_tab[k] = 0;
        pat_len   = 0;
        txt_len   = 0;
        miss_cnt  = 0;
        left_pos  = 0;
        win_start = 0;
        win_len   = 0;
        win_found = 1'b0;
        ovf_seen  = 1'b0;
    endfunction

    function automatic t_result cover_step(logic [OP_W-1:0] op, logic [SYMBOL_W-1:0] sym);
        t_result     r;
        int unsigned pos;
        int unsigned span;
        if (op == OP_CLEAR) begin
            clear_job();
        end else if (op == OP_PATTERN && sym < LETTERS) begin
            if (txt_len == 0) begin
                if (pat_len >= TEXT_CAP) begin
                    ovf_seen = 1'b1;
                end else begin
                    pat_len++;
                    need_tab[sym]++;
                    miss_cnt++;
                end
            end
        end else if (op == OP_TEXT && sym < LETTERS) begin
            if (txt_len >= TEXT_CAP) begin
                ovf_seen = 1'b1;
            end else begin
                pos = txt_len;
                text_mem[pos] = sym;
                txt_len++;
                if (pat_len != 0) begin
                    if (need_tab[sym] > 0) miss_cnt--;
                    need_tab[sym]--;
                    if (miss_cnt == 0) begin
                        while (left_pos < pos && need_tab[text_mem[left_pos]] < 0) begin
                            need_tab[text_mem[left_pos]]++;
                            left_pos++;
                        end
                        span = pos - left_pos + 1;
                        if (!win_found || span < win_len) begin
                            win_found = 1'b1;
                            win_start = left_pos;
                            win_len   = span;
                        end
                    end
                end
            end
        end
        r.found       = win_found;
        r.best_start  = win_found ? START_W'(win_start) : '0;
        r.best_length = win_found ? LENGTH_W'(win_len) : '0;
        r.overflow    = ovf_seen;
        return r;
    endfunction

    task automatic offer_beat(input logic [OP_W-1:0] op, input logic [SYMBOL_W-1:0] sym,
                              input bit typed, input t_result typed_res);
        t_result pred;
        while (!no_idle && $urandom_range(0, 99) < 18) begin
            push = 1'b0;
            @(negedge i_clk);
        end
        push     = 1'b1;
        i_op     = op;
        i_symbol = sym;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        pred = cover_step(op, sym);
        window_q.push_back(typed ? typed_res : pred);
        @(negedge i_clk);
    endtask

    task automatic maybe_noise();
        if ($urandom_range(0, 99) < 8) begin
            case ($urandom_range(0, 3))
                0: offer_beat(OP_UNUSED, SYMBOL_W'($urandom_range(0, 31)), 1'b0, '0);
                1: offer_beat(OP_PATTERN, SYMBOL_W'($urandom_range(26, 31)), 1'b0, '0);
                2: offer_beat(OP_TEXT, SYMBOL_W'($urandom_range(26, 31)), 1'b0, '0);
                default: offer_beat(OP_PATTERN, SYMBOL_W'($urandom_range(0, 25)), 1'b0, '0);
            endcase
        end
    endtask

    function automatic logic [SYMBOL_W-1:0] pick_letter(int base, int span);
        if ($urandom_range(0, 99) < 85) return SYMBOL_W'(base + $urandom_range(0, span - 1));
        return SYMBOL_W'($urandom_range(0, 25));
    endfunction

    task automatic random_job();
        int base, span, plen, tlen;
        base = $urandom_range(0, 22);
        span = $urandom_range(2, 4);
        plen = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
        tlen = $urandom_range(4, 30);
        offer_beat(OP_CLEAR, SYMBOL_W'($urandom_range(0, 31)), 1'b0, '0);
        stim_items++;
        repeat (plen) begin
            maybe_noise();
            offer_beat(OP_PATTERN, pick_letter(base, span), 1'b0, '0);
            stim_items++;
        end
        repeat (tlen) begin
            maybe_noise();
            offer_beat(OP_TEXT, pick_letter(base, span), 1'b0, '0);
            stim_items++;
        end
    endtask

    // One job that fills the text store: the widest window ends at the last position,
    // the text letters after it set overflow, and a late pattern letter is ignored.
    task automatic long_job();
        offer_beat(OP_CLEAR, '0, 1'b0, '0);
        offer_beat(OP_PATTERN, SYMBOL_W'(0), 1'b0, '0);
        offer_beat(OP_PATTERN, SYMBOL_W'(25), 1'b0, '0);
        offer_beat(OP_TEXT, SYMBOL_W'(0), 1'b0, '0);
        repeat (TEXT_CAP - 2) offer_beat(OP_TEXT, SYMBOL_W'($urandom_range(1, 24)), 1'b0, '0);
        offer_beat(OP_TEXT, SYMBOL_W'(25), 1'b0, '0);
        repeat (3) offer_beat(OP_TEXT, SYMBOL_W'($urandom_range(0, 25)), 1'b0, '0);
        offer_beat(OP_PATTERN, SYMBOL_W'(0), 1'b0, '0);
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            pop       <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            pop       <= 1'b0;
        end else begin
            pop <= no_idle || ($urandom_range(0, 99) >= 18);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (window_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected result beat");
            end else begin
                head_res = window_q.pop_front();
                if (o_found !== head_res.found || o_best_start !== head_res.best_start ||
                    o_best_length !== head_res.best_length ||
                    o_overflow !== head_res.overflow) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch: expected found %0d start %0d length %0d ovf %0d,",
                                 head_res.found, head_res.best_start, head_res.best_length,
                                 head_res.overflow);
                        $display("          actual   found %0d start %0d length %0d ovf %0d",
                                 o_found, o_best_start, o_best_length, o_overflow);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        dir_rows = '{
            '{OP_UNUSED,  5'd31, 1'b1, '0},
            '{OP_CLEAR,   5'd31, 1'b1, '0},
            '{OP_TEXT,    5'd0,  1'b1, '0},
            '{OP_TEXT,    5'd25, 1'b1, '0},
            '{OP_CLEAR,   5'd0,  1'b1, '0},
            '{OP_PATTERN, 5'd0,  1'b1, '0},
            '{OP_PATTERN, 5'd1,  1'b1, '0},
            '{OP_PATTERN, 5'd26, 1'b1, '0},
            '{OP_PATTERN, 5'd31, 1'b1, '0},
            '{OP_TEXT,    5'd1,  1'b1, '0},
            '{OP_TEXT,    5'd25, 1'b1, '0},
            '{OP_TEXT,    5'd0,  1'b1, '{1'b1, 10'd0, 11'd3, 1'b0}},
            '{OP_PATTERN, 5'd2,  1'b0, '0},
            '{OP_TEXT,    5'd31, 1'b0, '0},
            '{OP_TEXT,    5'd1,  1'b0, '0},
            '{OP_TEXT,    5'd0,  1'b0, '0},
            '{OP_UNUSED,  5'd0,  1'b0, '0},
            '{OP_CLEAR,   5'd16, 1'b1, '0},
            '{OP_PATTERN, 5'd25, 1'b1, '0},
            '{OP_TEXT,    5'd25, 1'b1, '{1'b1, 10'd0, 11'd1, 1'b0}},
            '{OP_CLEAR,   5'd15, 1'b1, '0}
        };
        clear_job();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[r]) offer_beat(dir_rows[r].op, dir_rows[r].sym, dir_rows[r].typed,
                                         dir_rows[r].res);

        hold_req = 1'b1;
        while (stim_items < RANDOM_ITEMS) begin
            no_idle = (stim_items >= 60 && stim_items < 140);
            random_job();
        end
        no_idle = 1'b0;
        long_job();
        push = 1'b0;

        while (window_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
+incdir+sv
sv/mwc_pkg.sv
sv/mwc_fifo.sv
sv/mwc_front.sv
sv/mwc_back.sv
sv/minimum_window_cover.sv
sv/mwc_checker.sv
sim/testbench.sv
